>>> rtl/mrw_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mrw_pkg
// Shared types and constants of the macroblock-to-raster writer.
// ----------------------------------------------------------------------------
package mrw_pkg;

  localparam int unsigned SAMPLE_W  = 8;
  localparam int unsigned CFG_W     = 8;
  localparam int unsigned ADDR_W    = 22;
  localparam int unsigned POS_W     = 9;
  // Effective size in macroblocks, up to 255.
  localparam int unsigned SIZE_W    = 9;
  // Sample line within a plane: up to 254 * 16 + 15.
  localparam int unsigned LINE_W    = 12;
  // Sample offset within a line: up to 254 * 16 + 15.
  localparam int unsigned COL_W     = 12;
  // Line stride in samples: up to 255 * 16.
  localparam int unsigned STRIDE_W  = 13;
  localparam int unsigned PROD_W    = LINE_W + STRIDE_W;

  localparam logic [POS_W-1:0] MB_LAST_POS = POS_W'(383);

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = 2;
  localparam int unsigned QCNT_W      = 3;

  typedef enum logic [1:0] {
    PLANE_Y = 2'd0,
    PLANE_U = 2'd1,
    PLANE_V = 2'd2
  } plane_e;

  typedef enum logic {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_index_e;

  // One classified sample on its way to the address unit.
  typedef struct packed {
    plane_e                plane;
    logic [LINE_W-1:0]     line;
    logic [STRIDE_W-1:0]   stride;
    logic [COL_W-1:0]      col;
    logic [SAMPLE_W-1:0]   sample;
    logic                  frame_end;
  } cmd_t;

endpackage
`default_nettype wire

>>> rtl/mrw_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mrw_front
// Position counters and per-sample classification into plane, line and column.
// ----------------------------------------------------------------------------
module mrw_front #(
  parameter int unsigned MAX_WIDTH_MBS  = 128,
  parameter int unsigned MAX_HEIGHT_MBS = 128
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          accept_i,
  input  wire logic [mrw_pkg::SAMPLE_W-1:0]  sample_i,
  input  wire logic [mrw_pkg::CFG_W-1:0]     width_mbs_i,
  input  wire logic [mrw_pkg::CFG_W-1:0]     height_mbs_i,
  output mrw_pkg::cmd_t                      cmd_o
);
  import mrw_pkg::*;

  localparam int unsigned CW = (MAX_WIDTH_MBS > 1) ? $clog2(MAX_WIDTH_MBS) : 1;
  localparam int unsigned RW = (MAX_HEIGHT_MBS > 1) ? $clog2(MAX_HEIGHT_MBS) : 1;

  logic [POS_W-1:0]  pos_q, pos_d;
  logic [CW-1:0]     col_q, col_d;
  logic [RW-1:0]     row_q, row_d;
  logic [SIZE_W-1:0] w_eff, h_eff, w_raw, h_raw;
  logic              mb_done, row_done, frame_done;

  // Clamp the programmed dimensions: zero reads as one, oversize as the maximum.
  assign w_raw = SIZE_W'(width_mbs_i);
  assign h_raw = SIZE_W'(height_mbs_i);

  always_comb begin
    if (w_raw == '0) begin
      w_eff = SIZE_W'(1);
    end else if (w_raw > SIZE_W'(MAX_WIDTH_MBS)) begin
      w_eff = SIZE_W'(MAX_WIDTH_MBS);
    end else begin
      w_eff = w_raw;
    end
    if (h_raw == '0) begin
      h_eff = SIZE_W'(1);
    end else if (h_raw > SIZE_W'(MAX_HEIGHT_MBS)) begin
      h_eff = SIZE_W'(MAX_HEIGHT_MBS);
    end else begin
      h_eff = h_raw;
    end
  end

  assign mb_done    = (pos_q == MB_LAST_POS);
  assign row_done   = mb_done && ((SIZE_W'(col_q) + SIZE_W'(1)) >= w_eff);
  assign frame_done = row_done && ((SIZE_W'(row_q) + SIZE_W'(1)) >= h_eff);

  always_comb begin
    pos_d = pos_q;
    col_d = col_q;
    row_d = row_q;
    if (accept_i) begin
      if (mb_done) begin
        pos_d = '0;
        if (row_done) begin
          col_d = '0;
          row_d = frame_done ? '0 : row_q + RW'(1);
        end else begin
          col_d = col_q + CW'(1);
        end
      end else begin
        pos_d = pos_q + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      col_q <= '0;
      row_q <= '0;
    end else begin
      pos_q <= pos_d;
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Luma occupies positions 0..255 as 16x16; U and V follow as 8x8 each.
  always_comb begin
    cmd_o.sample    = sample_i;
    cmd_o.frame_end = frame_done;
    if (!pos_q[8]) begin
      cmd_o.plane  = PLANE_Y;
      cmd_o.line   = (LINE_W'(row_q) << 4) | LINE_W'(pos_q[7:4]);
      cmd_o.col    = (COL_W'(col_q) << 4) | COL_W'(pos_q[3:0]);
      cmd_o.stride = STRIDE_W'(w_eff) << 4;
    end else begin
      cmd_o.plane  = pos_q[6] ? PLANE_V : PLANE_U;
      cmd_o.line   = (LINE_W'(row_q) << 3) | LINE_W'(pos_q[5:3]);
      cmd_o.col    = (COL_W'(col_q) << 3) | COL_W'(pos_q[2:0]);
      cmd_o.stride = STRIDE_W'(w_eff) << 3;
    end
  end

endmodule
`default_nettype wire

>>> rtl/mrw_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mrw_queue
// Short first-in first-out queue of classified samples between front and back.
// ----------------------------------------------------------------------------
module mrw_queue (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   push_i,
  input  wire mrw_pkg::cmd_t push_cmd_i,
  output logic        full_o,
  input  wire logic   pop_i,
  output logic        valid_o,
  output mrw_pkg::cmd_t pop_cmd_o
);
  import mrw_pkg::*;

  cmd_t              slots_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q;
  logic              do_push, do_pop;

  assign full_o    = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign valid_o   = (count_q != '0);
  assign pop_cmd_o = slots_q[rd_ptr_q];
  assign do_push   = push_i && !full_o;
  assign do_pop    = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + QCNT_W'(1);
        2'b01:   count_q <= count_q - QCNT_W'(1);
        default: count_q <= count_q;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> rtl/mrw_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mrw_back
// Address unit: line times stride, plus column, then the output register.
// ----------------------------------------------------------------------------
module mrw_back (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cmd_valid_i,
  input  wire mrw_pkg::cmd_t                 cmd_i,
  output logic                               pop_o,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [1:0]                         plane_o,
  output logic [mrw_pkg::ADDR_W-1:0]         write_address_o,
  output logic [mrw_pkg::SAMPLE_W-1:0]       sample_out_o,
  output logic                               frame_end_o
);
  import mrw_pkg::*;

  // Multiply stage.
  logic                s1_valid_q;
  logic [PROD_W-1:0]   s1_prod_q;
  logic [COL_W-1:0]    s1_col_q;
  plane_e              s1_plane_q;
  logic [SAMPLE_W-1:0] s1_sample_q;
  logic                s1_end_q;

  // Output word.
  logic                out_valid_q;
  logic [ADDR_W-1:0]   out_addr_q;
  plane_e              out_plane_q;
  logic [SAMPLE_W-1:0] out_sample_q;
  logic                out_end_q;

  logic                out_load, s1_load;
  logic [PROD_W-1:0]   addr_sum;

  assign out_load = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign s1_load  = !s1_valid_q || out_load;
  assign pop_o    = cmd_valid_i && s1_load;
  assign addr_sum = s1_prod_q + PROD_W'(s1_col_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_load) begin
        s1_valid_q <= cmd_valid_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      s1_prod_q   <= PROD_W'(cmd_i.line) * PROD_W'(cmd_i.stride);
      s1_col_q    <= cmd_i.col;
      s1_plane_q  <= cmd_i.plane;
      s1_sample_q <= cmd_i.sample;
      s1_end_q    <= cmd_i.frame_end;
    end
    if (out_load) begin
      // Keep the low address bits only.
      out_addr_q   <= addr_sum[ADDR_W-1:0];
      out_plane_q  <= s1_plane_q;
      out_sample_q <= s1_sample_q;
      out_end_q    <= s1_end_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign plane_o         = 2'(out_plane_q);
  assign write_address_o = out_addr_q;
  assign sample_out_o    = out_sample_q;
  assign frame_end_o     = out_end_q;

endmodule
`default_nettype wire

>>> rtl/macroblock_to_raster_writer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// macroblock_to_raster_writer
// Turns a 4:2:0 macroblock-ordered sample stream into raster plane writes.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o / sample_in_i) takes one sample
//   word per cycle while in_stall_o is low: 256 luma, then 64 U, then 64 V
//   per macroblock, macroblocks left to right and top to bottom.
//   Output channel (out_valid_o / out_stall_i) gives one write word per sample:
//   plane, raster address within that plane, the sample, and frame_end on the
//   last sample of the frame.
//   Configuration channel (cfg_valid_i / cfg_ready_o) writes frame width
//   (index 0) and height (index 1) in macroblocks; always ready. Write it only
//   while no words are in flight. Zero reads as one, oversize as the maximum.
//   From input acceptance to output valid a word passes the queue slot
//   (written at acceptance), then the multiply register, then the output register.
//   Throughput: one word per cycle while out_stall_i is low, set by the single
//   line-times-stride multiplier per word.
//   Reset clears the position to the top-left of macroblock zero, empties the
//   queue and sets both dimensions to one macroblock.
//   When the receiver stalls, the output word holds; the 4-entry queue keeps
//   taking input until full, then in_stall_o rises.
// ----------------------------------------------------------------------------
module macroblock_to_raster_writer #(
  parameter int unsigned MAX_WIDTH_MBS  = 128,
  parameter int unsigned MAX_HEIGHT_MBS = 128
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // Sample input
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [mrw_pkg::SAMPLE_W-1:0]  sample_in_i,
  // Write output
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [1:0]                         plane_o,
  output logic [mrw_pkg::ADDR_W-1:0]         write_address_o,
  output logic [mrw_pkg::SAMPLE_W-1:0]       sample_out_o,
  output logic                               frame_end_o,
  // Configuration
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic                          cfg_index_i,
  input  wire logic [mrw_pkg::CFG_W-1:0]     cfg_data_i
);
  import mrw_pkg::*;

  logic [CFG_W-1:0] width_mbs_q, height_mbs_q;
  logic             in_accept, queue_full, queue_valid, queue_pop;
  cmd_t             front_cmd, queue_cmd;

  // Configuration registers; the port never pushes back.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_mbs_q  <= CFG_W'(1);
      height_mbs_q <= CFG_W'(1);
    end else if (cfg_valid_i) begin
      case (reg_index_e'(cfg_index_i))
        REG_WIDTH:  width_mbs_q  <= cfg_data_i;
        REG_HEIGHT: height_mbs_q <= cfg_data_i;
        default:    width_mbs_q  <= width_mbs_q;
      endcase
    end
  end

  // Hold input while the queue is full.
  assign in_stall_o = queue_full;
  assign in_accept  = in_valid_i && !queue_full;

  mrw_front #(
    .MAX_WIDTH_MBS  (MAX_WIDTH_MBS),
    .MAX_HEIGHT_MBS (MAX_HEIGHT_MBS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (in_accept),
    .sample_i     (sample_in_i),
    .width_mbs_i  (width_mbs_q),
    .height_mbs_i (height_mbs_q),
    .cmd_o        (front_cmd)
  );

  mrw_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (in_accept),
    .push_cmd_i (front_cmd),
    .full_o     (queue_full),
    .pop_i      (queue_pop),
    .valid_o    (queue_valid),
    .pop_cmd_o  (queue_cmd)
  );

  mrw_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_valid_i     (queue_valid),
    .cmd_i           (queue_cmd),
    .pop_o           (queue_pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .plane_o         (plane_o),
    .write_address_o (write_address_o),
    .sample_out_o    (sample_out_o),
    .frame_end_o     (frame_end_o)
  );

endmodule
`default_nettype wire
